### hw/rtl/assert_macros.svh
// Assertion macros used by the decoder parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TDOD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdod assertion failed");

// Next-cycle implication, checked outside reset.
`define TDOD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdod assertion failed");

`endif

### hw/rtl/tdod_pkg.sv
// Types, codes and constants of the text delta op decoder.
package tdod_pkg;

   localparam int LENGTH_BITS_DEF = 16;
   localparam int BYTE_W          = 8;
   localparam int FIELD_W         = 16;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;

   // Parser phases.
   localparam logic [1:0] PH_COUNT   = 2'd0;
   localparam logic [1:0] PH_LITERAL = 2'd1;
   localparam logic [1:0] PH_DELIM   = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_COPY    = 2'd0;
   localparam logic [1:0] KIND_LITERAL = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   // Completion status codes.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_PAST_END   = 3'd1;
   localparam logic [2:0] ST_NO_DELIM   = 3'd2;
   localparam logic [2:0] ST_BAD_OP     = 3'd3;
   localparam logic [2:0] ST_MISMATCH   = 3'd4;
   localparam logic [2:0] ST_BAD_NUMBER = 3'd5;
   localparam logic [2:0] ST_TRUNCATED  = 3'd6;

   // Delta alphabet.
   localparam logic [7:0] CH_COPY   = 8'h3D;
   localparam logic [7:0] CH_SKIP   = 8'h2D;
   localparam logic [7:0] CH_INSERT = 8'h2B;
   localparam logic [7:0] CH_DELIM  = 8'h7C;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   // Register word index.
   localparam logic [0:0] REG_OLD_LENGTH = 1'b0;

   typedef struct packed {
      logic [1:0]         kind;
      logic [FIELD_W-1:0] copy_start;
      logic [FIELD_W-1:0] copy_length;
      logic [BYTE_W-1:0]  literal;
      logic               done_res;
      logic [2:0]         status;
   } rsp_type;

endpackage

### hw/rtl/tdod_if.sv
// Valid/ready channel interfaces for delta bytes and decoder results.
interface tdod_req_if import tdod_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] delta_byte;
   logic              last;

   modport source (output valid, output delta_byte, output last, input ready);
   modport sink   (input valid, input delta_byte, input last, output ready);
endinterface

interface tdod_rsp_if import tdod_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [FIELD_W-1:0] copy_start;
   logic [FIELD_W-1:0] copy_length;
   logic [BYTE_W-1:0]  literal;
   logic               done_res;
   logic [2:0]         status;

   modport source (output valid, output kind, output copy_start, output copy_length,
                   output literal, output done_res, output status, input ready);
   modport sink   (input valid, input kind, input copy_start, input copy_length,
                   input literal, input done_res, input status, output ready);
endinterface

### hw/rtl/tdod_parser.sv
// Delta op parser: state registers and the per-byte next-state and result logic.
`include "assert_macros.svh"

module tdod_parser import tdod_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [BYTE_W-1:0]  byte_in,
   input  logic               last_in,
   input  logic [FIELD_W-1:0] old_length,
   output logic               res_valid,
   output rsp_type            res
);

   localparam int PosW  = LENGTH_BITS + 1;
   localparam int ProdW = LENGTH_BITS + 4;
   localparam int CmpW  = (PosW + 1 > FIELD_W + 1) ? PosW + 1 : FIELD_W + 1;
   localparam logic [CmpW-1:0] PosMax = CmpW'({PosW{1'b1}});

   logic [1:0]             phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic                   seen_ff, seen_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic [PosW-1:0]        pos_ff, pos_in;
   logic [2:0]             err_ff, err_in;

   logic             is_digit;
   logic [ProdW-1:0] prod;
   logic [CmpW-1:0]  pos_sum;
   logic [CmpW-1:0]  old_len_ext;
   logic             emit;

   assign is_digit    = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
   assign prod        = (ProdW'(count_ff) << 3) + (ProdW'(count_ff) << 1)
                        + ProdW'(byte_in[3:0]);
   assign pos_sum     = CmpW'(pos_ff) + CmpW'(count_ff);
   assign old_len_ext = CmpW'(old_length);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      seen_in  = seen_ff;
      left_in  = left_ff;
      pos_in   = pos_ff;
      err_in   = err_ff;
      emit     = 1'b0;
      res      = '0;
      res.kind = KIND_STATUS;

      if (err_ff == ST_OK) begin
         case (phase_ff)
            PH_COUNT: begin
               if (is_digit) begin
                  if (prod[ProdW-1:LENGTH_BITS] != '0) begin
                     err_in = ST_BAD_NUMBER;
                  end else begin
                     count_in = prod[LENGTH_BITS-1:0];
                     seen_in  = 1'b1;
                  end
               end else if (!seen_ff) begin
                  err_in = ST_BAD_NUMBER;
               end else if (byte_in == CH_COPY) begin
                  if (pos_sum > old_len_ext) begin
                     err_in = ST_PAST_END;
                  end else begin
                     emit            = 1'b1;
                     res.kind        = KIND_COPY;
                     res.copy_start  = FIELD_W'(pos_ff);
                     res.copy_length = FIELD_W'(count_ff);
                     pos_in          = PosW'(pos_sum);
                  end
               end else if (byte_in == CH_SKIP) begin
                  // Skip positions saturate at PosMax; a position past the old end fails the final check.
                  pos_in = (pos_sum > PosMax) ? PosW'(PosMax) : PosW'(pos_sum);
               end else if (byte_in == CH_INSERT) begin
                  left_in  = count_ff;
                  phase_in = (count_ff == '0) ? PH_DELIM : PH_LITERAL;
               end else begin
                  err_in = ST_BAD_OP;
               end
               if ((err_in == ST_OK) && !is_digit) begin
                  count_in = '0;
                  seen_in  = 1'b0;
               end
            end
            PH_LITERAL: begin
               emit        = 1'b1;
               res.kind    = KIND_LITERAL;
               res.literal = byte_in;
               left_in     = left_ff - 1'b1;
               if (left_ff == LENGTH_BITS'(1)) begin
                  phase_in = PH_DELIM;
               end
            end
            default: begin
               if (byte_in == CH_DELIM) begin
                  phase_in = PH_COUNT;
               end else begin
                  err_in = ST_NO_DELIM;
               end
            end
         endcase
      end

      if (err_in != ST_OK) begin
         emit = 1'b0;
         res  = '0;
         res.kind = KIND_STATUS;
      end

      if (last_in) begin
         res.done_res = 1'b1;
         if (err_in != ST_OK) begin
            res.status = err_in;
         end else if ((phase_in != PH_COUNT) || seen_in) begin
            res.status = ST_TRUNCATED;
         end else if (CmpW'(pos_in) != old_len_ext) begin
            res.status = ST_MISMATCH;
         end
         // A finished stream leaves the parser ready for the next one.
         phase_in = PH_COUNT;
         count_in = '0;
         seen_in  = 1'b0;
         left_in  = '0;
         pos_in   = '0;
         err_in   = ST_OK;
      end
   end

   assign res_valid = emit || last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT;
         count_ff <= '0;
         seen_ff  <= 1'b0;
         left_ff  <= '0;
         pos_ff   <= '0;
         err_ff   <= ST_OK;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         seen_ff  <= seen_in;
         left_ff  <= left_in;
         pos_ff   <= pos_in;
         err_ff   <= err_in;
      end
   end

   `TDOD_ASSERT_NEXT(a_last_clears, clock, reset, step && last_in,
      (err_ff == ST_OK) && (phase_ff == PH_COUNT) && !seen_ff)
   `TDOD_ASSERT_NEXT(a_error_sticks, clock, reset, (err_ff != ST_OK) && !(step && last_in),
      err_ff == $past(err_ff))
   `TDOD_ASSERT_IMPLY(a_literal_run_nonempty, clock, reset, phase_ff == PH_LITERAL,
      (left_ff != '0) && !seen_ff)

endmodule

### hw/rtl/text_delta_op_decoder_core.sv
// Text delta op decoder: input register, parser, result register and config port.
// A byte accepted into the input register passes through the parser into the result
// register when it advances; a held result that is not taken stalls the advance.
// Throughput: one delta byte per cycle unless stalled; bytes that cause no result skip
// the result register. Reset (synchronous, active high) empties both registers, clears
// the parse state and sets old_length to zero.
module text_delta_op_decoder_core import tdod_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tdod_req_if.sink              req_chan,
   tdod_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               in_last_ff;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_data_ff;
   logic [FIELD_W-1:0] old_length_ff;

   logic    advance;
   logic    accept;
   logic    csr_write;
   logic    res_valid;
   rsp_type res;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_valid_in    = accept || (in_valid_ff && !advance);
   assign out_valid_in   = advance ? res_valid : (out_valid_ff && !rsp_chan.ready);

   tdod_parser #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .byte_in    (in_byte_ff),
      .last_in    (in_last_ff),
      .old_length (old_length_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_chan.delta_byte;
         in_last_ff <= req_chan.last;
      end
      if (advance && res_valid) begin
         out_data_ff <= res;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.kind        = out_data_ff.kind;
   assign rsp_chan.copy_start  = out_data_ff.copy_start;
   assign rsp_chan.copy_length = out_data_ff.copy_length;
   assign rsp_chan.literal     = out_data_ff.literal;
   assign rsp_chan.done_res    = out_data_ff.done_res;
   assign rsp_chan.status      = out_data_ff.status;

   // Configuration port: one register, written in the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         old_length_ff <= '0;
      end else if (csr_write && (csr_paddr[CSR_ADDR_W-1:2] == REG_OLD_LENGTH)) begin
         old_length_ff <= csr_pwdata[FIELD_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:2] == REG_OLD_LENGTH) begin
         csr_prdata = CSR_DATA_W'(old_length_ff);
      end
   end

endmodule
